// ===== rtl/core/iods_pkg.sv =====
package iods_pkg;

    // Field and register widths.
    localparam int DELAY_W    = 16;
    localparam int DEBOUNCE_W = 4;
    localparam int INTERVAL_W = 8;
    localparam int REPEATS_W  = 4;
    localparam int EVENT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default width of the elapsed seconds counter.
    localparam int DELAY_BITS_DEF = 16;

    // Register reset values.
    localparam logic [DELAY_W-1:0]    DELAY_RST    = 16'd30;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 4'd3;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd10;
    localparam logic [REPEATS_W-1:0]  REPEATS_RST  = 4'd6;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHUTDOWN_DELAY   = 2'd0,
        REG_DEBOUNCE_SAMPLES = 2'd1,
        REG_WARN_INTERVAL    = 2'd2,
        REG_WARN_REPEATS     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_MON  = 2'd0,
        MODE_CNT  = 2'd1,
        MODE_WARN = 2'd2,
        MODE_END  = 2'd3
    } mode_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_OFF     = 3'd1,
        EV_ON      = 3'd2,
        EV_WARN    = 3'd3,
        EV_RESTART = 3'd4
    } event_t;

    // One configuration write.
    typedef struct packed {
        logic                  en;
        reg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // One result item.
    typedef struct packed {
        logic   led;
        event_t ev;
    } result_t;

endpackage

// ===== rtl/core/iods_fsm.sv =====
module iods_fsm #(
    parameter int DELAY_BITS = iods_pkg::DELAY_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              acc_sense,
    input  iods_pkg::cfg_wr_t cfg,
    output iods_pkg::result_t res
);

    localparam int CMP_W = (DELAY_BITS > iods_pkg::DELAY_W) ? DELAY_BITS : iods_pkg::DELAY_W;
    localparam logic [iods_pkg::INTERVAL_W-1:0] INTERVAL_W_ONE =
        {{(iods_pkg::INTERVAL_W-1){1'b0}}, 1'b1};

    logic [iods_pkg::DELAY_W-1:0]    delay_reg;
    logic [iods_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic [iods_pkg::INTERVAL_W-1:0] interval_reg;
    logic [iods_pkg::REPEATS_W-1:0]  repeats_reg;

    iods_pkg::mode_t                 mode_reg, mode_next;
    logic [iods_pkg::DEBOUNCE_W-1:0] high_run_reg, high_run_next;
    logic [DELAY_BITS-1:0]           elapsed_reg, elapsed_next;
    logic [iods_pkg::INTERVAL_W-1:0] warn_ticks_reg, warn_ticks_next;
    logic [iods_pkg::REPEATS_W-1:0]  sent_reg, sent_next;
    logic                            led_reg, led_next;

    logic [iods_pkg::DEBOUNCE_W-1:0] high_run_inc;
    logic [iods_pkg::INTERVAL_W-1:0] warn_ticks_inc;
    logic [iods_pkg::REPEATS_W-1:0]  sent_inc;
    logic [CMP_W-1:0]                elapsed_ext;
    logic [CMP_W-1:0]                delay_ext;
    iods_pkg::event_t                ev;

    assign high_run_inc   = high_run_reg + 1'b1;
    assign warn_ticks_inc = warn_ticks_reg + 1'b1;
    assign sent_inc       = sent_reg + 1'b1;
    assign elapsed_ext    = CMP_W'(elapsed_reg);
    assign delay_ext      = CMP_W'(delay_reg);

    always_comb begin
        mode_next       = mode_reg;
        high_run_next   = high_run_reg;
        elapsed_next    = elapsed_reg;
        warn_ticks_next = warn_ticks_reg;
        sent_next       = sent_reg;
        led_next        = led_reg;
        ev              = iods_pkg::EV_NONE;
        case (mode_reg)
            iods_pkg::MODE_MON: begin
                if (acc_sense) begin
                    if (high_run_inc >= debounce_reg) begin
                        high_run_next = '0;
                        elapsed_next  = DELAY_BITS'(1);
                        led_next      = 1'b0;
                        mode_next     = iods_pkg::MODE_CNT;
                        ev            = iods_pkg::EV_OFF;
                    end else begin
                        high_run_next = high_run_inc;
                    end
                end else begin
                    high_run_next = '0;
                end
            end
            iods_pkg::MODE_CNT: begin
                if (!acc_sense) begin
                    led_next      = 1'b1;
                    high_run_next = '0;
                    mode_next     = iods_pkg::MODE_MON;
                    ev            = iods_pkg::EV_ON;
                end else if (elapsed_ext >= delay_ext) begin
                    warn_ticks_next = '0;
                    sent_next       = '0;
                    mode_next       = iods_pkg::MODE_WARN;
                    ev              = iods_pkg::EV_WARN;
                end else if (elapsed_reg != '1) begin
                    // The counter saturates, so a delay beyond its range never fires.
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            iods_pkg::MODE_WARN: begin
                if (warn_ticks_inc >= interval_reg) begin
                    warn_ticks_next = '0;
                    sent_next       = sent_inc;
                    ev              = iods_pkg::EV_WARN;
                    if (sent_inc >= repeats_reg) begin
                        mode_next = iods_pkg::MODE_END;
                    end
                end else begin
                    warn_ticks_next = warn_ticks_inc;
                end
            end
            iods_pkg::MODE_END: begin
                // The tick counter doubles as the flag that the restart went out.
                if (warn_ticks_reg == '0) begin
                    warn_ticks_next = INTERVAL_W_ONE;
                    ev              = iods_pkg::EV_RESTART;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    assign res.ev  = ev;
    assign res.led = led_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= iods_pkg::MODE_MON;
            high_run_reg   <= '0;
            elapsed_reg    <= '0;
            warn_ticks_reg <= '0;
            sent_reg       <= '0;
            led_reg        <= 1'b1;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            high_run_reg   <= high_run_next;
            elapsed_reg    <= elapsed_next;
            warn_ticks_reg <= warn_ticks_next;
            sent_reg       <= sent_next;
            led_reg        <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= iods_pkg::DELAY_RST;
            debounce_reg <= iods_pkg::DEBOUNCE_RST;
            interval_reg <= iods_pkg::INTERVAL_RST;
            repeats_reg  <= iods_pkg::REPEATS_RST;
        end else if (cfg.en) begin
            case (cfg.idx)
                iods_pkg::REG_SHUTDOWN_DELAY: begin
                    // The delay is frozen while a countdown runs.
                    if (mode_reg != iods_pkg::MODE_CNT) begin
                        delay_reg <= cfg.data[iods_pkg::DELAY_W-1:0];
                    end
                end
                iods_pkg::REG_DEBOUNCE_SAMPLES: begin
                    debounce_reg <= cfg.data[iods_pkg::DEBOUNCE_W-1:0];
                end
                iods_pkg::REG_WARN_INTERVAL: begin
                    interval_reg <= cfg.data[iods_pkg::INTERVAL_W-1:0];
                end
                iods_pkg::REG_WARN_REPEATS: begin
                    repeats_reg <= cfg.data[iods_pkg::REPEATS_W-1:0];
                end
                default: begin
                    delay_reg <= delay_reg;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/iods_outq.sv =====
module iods_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  iods_pkg::result_t push_data,
    input  logic              pop,
    output logic              not_full,
    output logic              not_empty,
    output iods_pkg::result_t head
);

    iods_pkg::result_t q_reg [2];
    logic [1:0]        count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = q_reg[0];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload entries carry no reset.
    always_ff @(posedge aclk) begin
        if (pop && push) begin
            // Push happens only with one entry held, so the new item becomes the head.
            q_reg[0] <= push_data;
        end else if (pop) begin
            q_reg[0] <= q_reg[1];
        end else if (push) begin
            q_reg[count_reg[0]] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ignition_off_delayed_shutdown.sv =====
// Ignition-off delayed shutdown monitor.
//
// Each item on the s_ channel is one check tick, normally one second, and
// carries the sampled ignition pin in s_tdata bit 0 (1 means ignition off).
// Every accepted item produces exactly one result item on the m_ channel: an
// event code and the power LED state after that tick.
// The four configuration registers are written through cfg_wr_en, cfg_addr and
// cfg_wdata, one write per cycle with no wait; writes are meant for idle time.
// The state machine updates its counters as an item is accepted, and the
// result, registered in the queue, appears on m_tvalid in the next cycle.
// Throughput is one item per cycle while the result queue has room.
// A two-entry result queue sits between the state machine and the m_ side, so
// an item is still accepted while one result waits; s_tready drops only when
// two results are waiting on a stalled receiver, and rises as soon as one is
// taken. Nothing is lost or repeated under any stall pattern.
// A synchronous active-low reset on aresetn empties the queue, restores the
// register defaults and returns the block to monitoring with the LED lit.
// After the restart event the block stays halted until the next reset.
module ignition_off_delayed_shutdown #(
    parameter int DELAY_BITS = iods_pkg::DELAY_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items. s_tdata fields from bit 0: acc_sense[0], zero padding [7:1].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    // Result items. m_tdata fields from bit 0: event_res[2:0], power_led_on[3],
    // zero padding [7:4].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [iods_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [iods_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic              accept;
    logic              deliver;
    iods_pkg::cfg_wr_t cfg;
    iods_pkg::result_t step_res;
    iods_pkg::result_t head;

    assign accept   = s_tvalid && s_tready;
    assign deliver  = m_tvalid && m_tready;

    assign cfg.en   = cfg_wr_en;
    assign cfg.idx  = iods_pkg::reg_idx_t'(cfg_addr);
    assign cfg.data = cfg_wdata;

    iods_fsm #(
        .DELAY_BITS(DELAY_BITS)
    ) u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (accept),
        .acc_sense (s_tdata[0]),
        .cfg       (cfg),
        .res       (step_res)
    );

    iods_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (step_res),
        .pop       (deliver),
        .not_full  (s_tready),
        .not_empty (m_tvalid),
        .head      (head)
    );

    assign m_tdata = {4'b0000, head.led, head.ev};

endmodule

// ===== rtl/core/iods_checker.sv =====
module iods_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Reset empties the result queue.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    // Every accepted item leaves a result waiting in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Ignition off darkens the LED, ignition on lights it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == iods_pkg::EV_OFF) |-> !m_tdata[3])
        else $error("LED lit on ignition off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == iods_pkg::EV_ON) |-> m_tdata[3])
        else $error("LED dark on ignition on");

endmodule

bind ignition_off_delayed_shutdown iods_checker u_iods_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_ignition_off_delayed_shutdown.sv =====
// Self-checking bench for the ignition-off delayed shutdown monitor.
module tb_ignition_off_delayed_shutdown;
    import iods_pkg::*;

    // Cycles without any item moving on either channel before the run is
    // declared hung. The longest legal quiet stretch is a long receiver stall
    // or a long sender gap, so this is far beyond a correct run.
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 170;

    // Tracks the monitor's state machine in step with the block. Every
    // accepted tick yields exactly one expected report, which is queued in
    // order and compared against the m_ channel as results arrive.
    class shutdown_scoreboard;
        logic [DELAY_W-1:0]        delay_s;
        logic [DEBOUNCE_W-1:0]     debounce;
        logic [INTERVAL_W-1:0]     interval;
        logic [REPEATS_W-1:0]      repeats;
        mode_t                     mode;
        logic [DEBOUNCE_W-1:0]     high_run;
        logic [DELAY_BITS_DEF-1:0] elapsed;
        logic [INTERVAL_W-1:0]     warn_ticks;
        logic [REPEATS_W-1:0]      warnings_sent;
        logic                      led;
        result_t                   pending_reports[$];
        int                        errors;
        int                        reports_checked;
        int                        event_count[8];

        function new();
            delay_s         = DELAY_RST;
            debounce        = DEBOUNCE_RST;
            interval        = INTERVAL_RST;
            repeats         = REPEATS_RST;
            mode            = MODE_MON;
            high_run        = '0;
            elapsed         = '0;
            warn_ticks      = '0;
            warnings_sent   = '0;
            led             = 1'b1;
            errors          = 0;
            reports_checked = 0;
            foreach (event_count[i]) event_count[i] = 0;
        endfunction

        // The delay register is frozen while a countdown is running.
        function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SHUTDOWN_DELAY: begin
                    if (mode != MODE_CNT) delay_s = value[DELAY_W-1:0];
                end
                REG_DEBOUNCE_SAMPLES: debounce = value[DEBOUNCE_W-1:0];
                REG_WARN_INTERVAL:    interval = value[INTERVAL_W-1:0];
                REG_WARN_REPEATS:     repeats  = value[REPEATS_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_tick(logic sense);
            event_t  ev;
            result_t rep;
            ev = EV_NONE;
            case (mode)
                MODE_MON: begin
                    if (sense) begin
                        high_run = high_run + 1'b1;
                        // A zero debounce length is met by the first high sample.
                        if (high_run >= debounce) begin
                            high_run = '0;
                            elapsed  = DELAY_BITS_DEF'(1);
                            led      = 1'b0;
                            mode     = MODE_CNT;
                            ev       = EV_OFF;
                        end
                    end else begin
                        high_run = '0;
                    end
                end
                MODE_CNT: begin
                    if (!sense) begin
                        led      = 1'b1;
                        high_run = '0;
                        mode     = MODE_MON;
                        ev       = EV_ON;
                    end else if (elapsed >= delay_s) begin
                        warn_ticks    = '0;
                        warnings_sent = '0;
                        mode          = MODE_WARN;
                        ev            = EV_WARN;
                    end else if (elapsed != '1) begin
                        elapsed = elapsed + 1'b1;
                    end
                end
                MODE_WARN: begin
                    // The sample does not matter once warnings have started.
                    warn_ticks = warn_ticks + 1'b1;
                    if (warn_ticks >= interval) begin
                        warn_ticks    = '0;
                        warnings_sent = warnings_sent + 1'b1;
                        ev            = EV_WARN;
                        if (warnings_sent >= repeats) mode = MODE_END;
                    end
                end
                default: begin
                    if (warn_ticks == '0) begin
                        warn_ticks = INTERVAL_W'(1);
                        ev         = EV_RESTART;
                    end
                end
            endcase
            rep.led = led;
            rep.ev  = ev;
            pending_reports.push_back(rep);
            event_count[ev]++;
        endfunction

        // m_tdata: event_res in [2:0], power_led_on in [3].
        function void check_report(logic [7:0] data);
            result_t exp;
            if (pending_reports.size() == 0) begin
                $error("result item 0x%02h arrived with no tick outstanding", data);
                errors++;
                return;
            end
            exp = pending_reports.pop_front();
            if (data[2:0] !== exp.ev) begin
                $error("event_res: expected %0d, got %0d", exp.ev, data[2:0]);
                errors++;
            end
            if (data[3] !== exp.led) begin
                $error("power_led_on: expected %0d, got %0d", exp.led, data[3]);
                errors++;
            end
            reports_checked++;
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = REG_SHUTDOWN_DELAY;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    shutdown_scoreboard sb;

    // Traffic shaping knobs, changed from phase to phase so that some
    // stretches run at full rate on both sides.
    bit src_gaps_on    = 1'b0;
    bit sink_stalls_on = 1'b0;
    int ready_hold     = 0;
    int idle_cycles    = 0;
    int ticks_sent     = 0;
    int reg_settings   = 0;

    ignition_off_delayed_shutdown i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver back-pressure. Ready is held for a random number of cycles;
    // stalls are mostly short with an occasional long one.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (!sink_stalls_on || $urandom_range(0, 99) < 70) begin
            m_tready   <= 1'b1;
            ready_hold = int'($urandom_range(0, 8));
        end else begin
            m_tready   <= 1'b0;
            ready_hold = ($urandom_range(0, 9) != 0) ? int'($urandom_range(0, 3))
                                                      : int'($urandom_range(10, 50));
        end
    end

    // Every result item that moves is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_report(m_tdata);
    end

    // Hang detection: counts cycles in which no item moves on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offers one tick and returns at the edge where it is taken. A gap of
    // zero keeps tvalid high so that ticks go back to back.
    task automatic send_tick(input logic sense);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 99) >= 60) begin
            gap = ($urandom_range(0, 9) != 0) ? int'($urandom_range(1, 3))
                                              : int'($urandom_range(8, 40));
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, sense};
        do @(posedge aclk); while (!s_tready);
        sb.take_tick(sense);
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every expected report is back.
    // Each tick yields exactly one report, so the block is idle afterwards.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_reports.size() != 0) @(posedge aclk);
    endtask

    // One register write. The enable is left high when another write follows
    // so that it is never lowered and raised within the same step.
    task automatic write_cfg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value,
                             input bit more);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
        if (!more) cfg_wr_en <= 1'b0;
    endtask

    // Writes all four registers. Bits above each register's width carry
    // random junk, which the block must drop.
    task automatic apply_regs(input logic [DELAY_W-1:0] delay_v,
                              input logic [DEBOUNCE_W-1:0] debounce_v,
                              input logic [INTERVAL_W-1:0] interval_v,
                              input logic [REPEATS_W-1:0] repeats_v);
        logic [31:0] junk;
        junk = $urandom();
        write_cfg(REG_SHUTDOWN_DELAY, delay_v, 1'b1);
        write_cfg(REG_DEBOUNCE_SAMPLES, {junk[11:0], debounce_v}, 1'b1);
        write_cfg(REG_WARN_INTERVAL, {junk[19:12], interval_v}, 1'b1);
        write_cfg(REG_WARN_REPEATS, {junk[31:20], repeats_v}, 1'b0);
        reg_settings++;
    endtask

    function automatic logic [INTERVAL_W-1:0] pick_interval();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return INTERVAL_W'(1);
            2:       return '1;
            default: return INTERVAL_W'($urandom_range(2, 254));
        endcase
    endfunction

    function automatic logic [REPEATS_W-1:0] pick_repeats();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return REPEATS_W'(1);
            2:       return '1;
            default: return REPEATS_W'($urandom_range(2, 14));
        endcase
    endfunction

    // Monitoring and countdown traffic under one register setting. Ticks come
    // in runs of high and low samples, with high runs long enough to cross
    // the debounce length and carry the countdown up to the delay. Since the
    // warning sequence ends in a halt that only reset clears, a high sample is
    // never offered when it would start warnings; a low one goes instead.
    task automatic run_phase(input int n_ticks);
        int   run_left;
        int   deb_eff;
        logic level;
        logic sense;
        run_left = 0;
        level    = 1'b0;
        for (int n = 0; n < n_ticks; n++) begin
            if (run_left == 0) begin
                level   = !level;
                deb_eff = (sb.debounce == '0) ? 1 : int'(sb.debounce);
                run_left = level ? int'($urandom_range(1, deb_eff + 45))
                                 : int'($urandom_range(1, 4));
            end
            sense = level;
            if ($urandom_range(0, 19) == 0) sense = 1'($urandom_range(0, 1));
            if (sb.mode == MODE_CNT && sb.elapsed >= sb.delay_s) sense = 1'b0;
            run_left--;
            send_tick(sense);
        end
    endtask

    initial begin
        logic [DELAY_W-1:0]    final_delay;
        logic [INTERVAL_W-1:0] final_interval;
        logic [REPEATS_W-1:0]  final_repeats;
        logic [DELAY_W-1:0]    delay_v;
        logic [DEBOUNCE_W-1:0] debounce_v;

        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed start under the reset defaults: a high run broken before
        // the debounce length, then ignition off, a short countdown and
        // ignition back on.
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();

        // A zero debounce length behaves like one: every single high sample
        // while monitoring declares ignition off. The delay sits at its top.
        apply_regs('1, '0, '1, '1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();

        // Random phases, each with a fresh register setting and its own mix
        // of sender gaps and receiver stalls. The first runs at full rate.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            src_gaps_on    = (p != 0) && ($urandom_range(0, 3) != 0);
            sink_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       delay_v = '1;
                default: delay_v = DELAY_W'($urandom_range(15, 60));
            endcase
            case ($urandom_range(0, 4))
                0:       debounce_v = '0;
                1:       debounce_v = DEBOUNCE_W'(1);
                2:       debounce_v = '1;
                default: debounce_v = DEBOUNCE_W'($urandom_range(2, 14));
            endcase
            apply_regs(delay_v, debounce_v, pick_interval(), pick_repeats());
            run_phase(PHASE_TICKS);
            wait_idle();
        end

        // Closing sequence: the full warning cycle, which halts the block.
        // A low tick first brings it back to monitoring so the new delay lands.
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        send_tick(1'b0);
        wait_idle();
        case ($urandom_range(0, 2))
            0:       final_delay = '0;
            1:       final_delay = DELAY_W'(1);
            default: final_delay = DELAY_W'($urandom_range(2, 30));
        endcase
        final_interval = pick_interval();
        final_repeats  = pick_repeats();
        // A long interval comes with a single repeat so the closing run stays short.
        if (final_interval > 8'd16 && final_repeats > 4'd1) final_repeats = 4'd1;
        apply_regs(final_delay, DEBOUNCE_W'($urandom_range(0, 15)), final_interval,
                   final_repeats);
        while (sb.mode != MODE_CNT) send_tick(1'b1);

        // A delay write during the countdown must be ignored, so the warning
        // still comes at the delay programmed above.
        wait_idle();
        write_cfg(REG_SHUTDOWN_DELAY, '1, 1'b0);
        while (sb.mode != MODE_END) begin
            send_tick((sb.mode == MODE_CNT) ? 1'b1 : 1'($urandom_range(0, 1)));
        end
        // Once halted, the restart is reported once and then nothing more.
        repeat (12) send_tick(1'($urandom_range(0, 1)));
        wait_idle();
        repeat (8) @(posedge aclk);

        if (sb.pending_reports.size() != 0) begin
            $error("%0d expected result items never arrived", sb.pending_reports.size());
            sb.errors++;
        end

        $display("Checked %0d result items from %0d ticks over %0d register settings.",
                 sb.reports_checked, ticks_sent, reg_settings);
        $display("Saw %0d off, %0d on, %0d warning, %0d restart events (%0d, %0d).",
                 sb.event_count[EV_OFF], sb.event_count[EV_ON], sb.event_count[EV_WARN],
                 sb.event_count[EV_RESTART], final_interval, final_repeats);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
